[design/fsad_pkg.sv]
// Package: widths, constants and the binary32 adder function for the SAD accumulator.
`timescale 1ns / 1ps
`default_nettype none
package fsad_pkg;

  localparam int unsigned LanesDefault = 8;
  localparam logic [31:0] QnanBits = 32'h7FC00000;

  // Replaces any NaN pattern by the canonical quiet NaN.
  function automatic logic [31:0] canon(input logic [31:0] u);
    logic [31:0] r;
    r = u;
    if (u[30:23] == 8'hFF && u[22:0] != 23'd0) begin
      r = QnanBits;
    end
    return r;
  endfunction

  // Count of leading zeros of a 27-bit value, as a priority search.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // binary32 addition, round to nearest even, subnormals kept, NaN canonical.
  function automatic logic [31:0] fadd(input logic [31:0] x, input logic [31:0] y);
    logic        xs, ys, bs, ss, rs;
    logic [7:0]  xe, ye, be, se;
    logic [23:0] xm, ym, bm, sm;
    logic [26:0] bx, sx, al;
    logic [27:0] sum;
    logic [8:0]  d, ex;
    logic [4:0]  lz;
    logic [26:0] nm;
    logic [23:0] mant;
    logic [24:0] rnd;
    logic        sticky, xnan, ynan, xinf, yinf;
    logic [31:0] r;
    xs = x[31]; ys = y[31];
    xe = x[30:23]; ye = y[30:23];
    xnan = (xe == 8'hFF) && (x[22:0] != 23'd0);
    ynan = (ye == 8'hFF) && (y[22:0] != 23'd0);
    xinf = (xe == 8'hFF) && (x[22:0] == 23'd0);
    yinf = (ye == 8'hFF) && (y[22:0] == 23'd0);
    xm = {(xe != 8'd0), x[22:0]};
    ym = {(ye != 8'd0), y[22:0]};
    if (xe == 8'd0) xe = 8'd1;
    if (ye == 8'd0) ye = 8'd1;
    r = 32'd0;
    if (xnan || ynan || (xinf && yinf && (xs != ys))) begin
      r = QnanBits;
    end else if (xinf) begin
      r = x;
    end else if (yinf) begin
      r = y;
    end else begin
      if ({xe, xm} >= {ye, ym}) begin
        bs = xs; be = xe; bm = xm; ss = ys; se = ye; sm = ym;
      end else begin
        bs = ys; be = ye; bm = ym; ss = xs; se = xe; sm = xm;
      end
      d = {1'b0, be} - {1'b0, se};
      bx = {bm, 3'b000};
      sx = {sm, 3'b000};
      if (d >= 9'd27) begin
        al = {26'd0, (sm != 24'd0)};
      end else begin
        al = sx >> d[4:0];
        sticky = 1'b0;
        for (int i = 0; i < 27; i++) begin
          if (i < 32'(d) && sx[i]) sticky = 1'b1;
        end
        al[0] = al[0] | sticky;
      end
      if (bs == ss) sum = {1'b0, bx} + {1'b0, al};
      else sum = {1'b0, bx} - {1'b0, al};
      rs = bs;
      if (sum == 28'd0) begin
        r = {(xs & ys), 31'd0};
      end else begin
        ex = {1'b0, be};
        if (sum[27]) begin
          nm = sum[27:1] | {26'd0, sum[0]};
          ex = ex + 9'd1;
        end else begin
          lz = lzc27(sum[26:0]);
          // Normalise left, but never below the subnormal exponent.
          if ({4'd0, lz} >= ex) begin
            nm = sum[26:0] << (ex[4:0] - 5'd1);
            ex = 9'd0;
          end else begin
            nm = sum[26:0] << lz;
            ex = ex - {4'd0, lz};
          end
        end
        mant = nm[26:3];
        rnd = {1'b0, mant};
        if (nm[2] && (nm[1] || nm[0] || mant[0])) rnd = rnd + 25'd1;
        if (rnd[24]) begin
          rnd = rnd >> 1;
          ex = ex + 9'd1;
        end
        if (ex != 9'd0 && rnd[23] == 1'b0) ex = 9'd0;
        if (ex == 9'd0 && rnd[23]) ex = 9'd1;
        if (ex >= 9'd255) r = {rs, 8'hFF, 23'd0};
        else r = {rs, ex[7:0], rnd[22:0]};
      end
    end
    return canon(r);
  endfunction

endpackage
`default_nettype wire

[design/fsad_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fsad_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                    wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                    rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[design/float_sad_interleaved_accumulator.sv]
// Top level of the binary32 sum-of-absolute-differences accumulator.
// Sequence: an ordinary beat runs in order: the accepting cycle issues the lane read, then
// a wait cycle, then add and write back, after which the next beat can be taken. A beat
// marked end_of_run then reduces the lanes as a pairwise tree (lane i plus lane i+2^d at
// level d) through the accumulation adder: LANES-1 additions, each of which reads the upper
// lane, reads the lower lane, then adds and writes back. The total is then held on the output
// register, and no new beat is taken until it is accepted; a beat may be taken in the same
// cycle as the total. Lane sums live in a one-read, one-write RAM, and a valid bit per lane
// makes a lane not written since the last run read as +0, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module float_sad_interleaved_accumulator #(
  parameter int unsigned LANES = fsad_pkg::LanesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] a_bits_i,
  input  wire logic [31:0] b_bits_i,
  input  wire logic        end_of_run_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic [31:0]      total_bits_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);
  localparam int unsigned AW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned CW = $clog2(LANES + 1);

  typedef enum logic [2:0] {
    StIdle, StAccRd, StAccWr, StRedHi, StRedLo, StRedAdd, StOut
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    ptr_q, lane_q, rd_lane_q;
  logic [CW-1:0]    red_i_q, step_q;
  logic [31:0]      diff_q, acc_q;
  logic             last_q;
  logic [LANES-1:0] vld_q;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [31:0]      wdata, rdata, lane_val, sum;

  fsad_ram #(.Width(32), .Depth(LANES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // The read data belongs to the lane addressed in the previous cycle; an unwritten lane counts as +0.
  assign lane_val = vld_q[rd_lane_q] ? rdata : 32'd0;
  assign sum = fsad_pkg::fadd(lane_val, (state_q == StAccWr) ? diff_q : acc_q);
  assign we = (state_q == StAccWr) || (state_q == StRedAdd);
  assign waddr = (state_q == StRedAdd) ? AW'(red_i_q) : lane_q;
  assign wdata = sum;
  assign in_ready_o = (state_q == StIdle) || (state_q == StOut && out_ready_i);

  always_comb begin
    raddr = lane_q;
    unique case (state_q)
      StRedHi: raddr = AW'(red_i_q + step_q);
      StRedLo, StRedAdd: raddr = AW'(red_i_q);
      default: begin
        if (in_valid_i && in_ready_o) raddr = ptr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] dd;
    logic [31:0] nxt_i;
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      lane_q      <= '0;
      rd_lane_q   <= '0;
      red_i_q     <= '0;
      step_q      <= '0;
      vld_q       <= '0;
      last_q      <= 1'b0;
      out_valid_o <= 1'b0;
      diff_q      <= '0;
      acc_q       <= '0;
      total_bits_o <= '0;
    end else begin
      rd_lane_q <= raddr;
      unique case (state_q)
        StIdle, StOut: begin
          if (state_q == StOut && out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= StIdle;
          end
          if (in_valid_i && in_ready_o) begin
            dd = fsad_pkg::fadd(a_bits_i, {~b_bits_i[31], b_bits_i[30:0]});
            diff_q  <= (dd == fsad_pkg::QnanBits) ? dd : {1'b0, dd[30:0]};
            lane_q  <= ptr_q;
            last_q  <= end_of_run_i;
            state_q <= StAccRd;
          end
        end
        StAccRd: state_q <= StAccWr;
        StAccWr: begin
          if (last_q && LANES == 1) begin
            total_bits_o <= sum;
            out_valid_o  <= 1'b1;
            vld_q   <= '0;
            ptr_q   <= '0;
            state_q <= StOut;
          end else begin
            vld_q[lane_q] <= 1'b1;
            ptr_q <= (32'(ptr_q) + 1 >= LANES) ? '0 : AW'(32'(ptr_q) + 1);
            if (last_q) begin
              red_i_q <= '0;
              step_q  <= CW'(1);
              state_q <= StRedHi;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        // Tree step: the upper lane is captured first, then added into the lower lane.
        StRedHi: state_q <= StRedLo;
        StRedLo: begin
          acc_q   <= lane_val;
          state_q <= StRedAdd;
        end
        StRedAdd: begin
          nxt_i = 32'(red_i_q) + 2 * 32'(step_q);
          if (nxt_i + 32'(step_q) < LANES) begin
            vld_q[AW'(red_i_q)] <= 1'b1;
            red_i_q <= CW'(nxt_i);
            state_q <= StRedHi;
          end else if (2 * 32'(step_q) < LANES) begin
            vld_q[AW'(red_i_q)] <= 1'b1;
            step_q  <= CW'(2 * 32'(step_q));
            red_i_q <= '0;
            state_q <= StRedHi;
          end else begin
            total_bits_o <= sum;
            out_valid_o  <= 1'b1;
            vld_q   <= '0;
            ptr_q   <= '0;
            state_q <= StOut;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
